### design/srt_pkg.sv
package srt_pkg;

    localparam int KEY_W   = 16;
    localparam int REF_W   = 14;
    localparam int GRADE_W = 11;
    localparam int POS_W   = 7;
    localparam int CNT_W   = 7;

    // slave tdata: key, offer_ref, grade, zero pad to 48 bits
    localparam int S_DATA_W = 48;
    localparam int S_USER_W = 1;
    // master tdata: position, count, zero pad to 16 bits
    localparam int M_DATA_W = 16;
    localparam int M_USER_W = 2;

    typedef enum logic {
        FUNC_INS = 1'b0,
        FUNC_DEL = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_DUP     = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [REF_W-1:0]   offer_ref;
        logic [GRADE_W-1:0] grade;
    } t_rec;

    // per-cycle commands broadcast to every cell of the row
    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

### design/sorted_record_table.sv
// Sorted record table: up to DEPTH records (key, offer_ref, grade) kept in
// ascending unique key order in a row of cells. tuser on the slave side selects
// insert (0) or delete (1); each transfer in gives exactly one transfer out with
// status, position and the entry count after the operation. On acceptance the
// item is latched and every cell compares its key in parallel; the update step
// then resolves hit and slot and shifts the row one cell up or down. A result
// held by a stalled master side delays the update step; no new item is taken
// until the current one has left the row. The table is usable straight out of
// reset, with no clearing pass.
module sorted_record_table
    import srt_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,  // key[15:0], offer_ref[29:16], grade[40:30]
    input  logic [S_USER_W-1:0] i_s_axis_tuser,  // func[0]
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [M_DATA_W-1:0] o_m_axis_tdata,  // position[6:0], count[13:7]
    output logic [M_USER_W-1:0] o_m_axis_tuser   // status[1:0]
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_UPD
    } t_state;

    t_state  r_state;
    t_func   r_func;
    t_rec    r_new;
    logic [CW-1:0] r_count;
    logic    r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    t_status r_out_status;

    logic      w_accept;
    logic      w_go;
    logic      w_hit;
    logic      w_full;
    t_cell_ctl w_ctl;
    t_rec      w_in_rec;
    t_rec      w_rec [DEPTH];
    logic [DEPTH-1:0] w_ge;
    logic [DEPTH-1:0] w_eq;
    logic [DEPTH-1:0] w_bound;
    logic [CW-1:0]    w_pos;
    logic [CW-1:0]    n_count;
    t_status          n_status;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_go     = (r_state == S_UPD) && (!r_out_valid || i_m_axis_tready);

    assign w_in_rec.key       = i_s_axis_tdata[KEY_W-1:0];
    assign w_in_rec.offer_ref = i_s_axis_tdata[KEY_W+REF_W-1:KEY_W];
    assign w_in_rec.grade     = i_s_axis_tdata[KEY_W+REF_W+GRADE_W-1:KEY_W+REF_W];

    assign w_hit  = |w_eq;
    assign w_full = (r_count == CW'(DEPTH));

    assign w_ctl.cmp = w_accept;
    assign w_ctl.ins = w_go && (r_func == FUNC_INS) && !w_hit && !w_full;
    assign w_ctl.del = w_go && (r_func == FUNC_DEL) && w_hit;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_rec w_prev;
        t_rec w_next;
        logic w_prev_ge;
        if (i == 0) begin : g_first
            assign w_prev    = r_new;
            assign w_prev_ge = 1'b0;
        end else begin : g_mid
            assign w_prev    = w_rec[i-1];
            assign w_prev_ge = w_ge[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign w_next = w_rec[i];
        end else begin : g_inner
            assign w_next = w_rec[i+1];
        end
        assign w_bound[i] = w_ge[i] && !w_prev_ge;

        srt_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_cmp_key (w_in_rec.key),
            .i_occ     (r_count > CW'(i)),
            .i_new     (r_new),
            .i_prev    (w_prev),
            .i_prev_ge (w_prev_ge),
            .i_next    (w_next),
            .o_rec     (w_rec[i]),
            .o_ge      (w_ge[i]),
            .o_eq      (w_eq[i])
        );
    end

    // slot = first cell that is not less; all less only when the row is full
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_pos = w_pos | (w_bound[i] ? CW'(i) : '0);
        end
        if (!w_ge[DEPTH-1]) begin
            w_pos = CW'(DEPTH);
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        unique case (r_func)
            FUNC_INS: begin
                priority if (w_hit) begin
                    n_status = ST_DUP;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            FUNC_DEL: begin
                if (w_hit) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_status = ST_MISSING;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result replaces the one leaving in the same cycle
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func  <= t_func'(i_s_axis_tuser[0]);
                        r_new   <= w_in_rec;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (w_go) begin
                        r_count      <= n_count;
                        r_out_status <= n_status;
                        r_out_data   <= {2'b00, CNT_W'(n_count), POS_W'(w_pos)};
                        r_state      <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;

endmodule

### design/srt_cell.sv
module srt_cell
    import srt_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [KEY_W-1:0] i_cmp_key,
    input  logic             i_occ,
    input  t_rec             i_new,
    input  t_rec             i_prev,
    input  logic             i_prev_ge,
    input  t_rec             i_next,
    output t_rec             o_rec,
    output logic             o_ge,
    output logic             o_eq
);

    t_rec r_rec;
    logic r_ge;
    logic r_eq;

    // an empty cell counts as "not less", so the ge flags form a thermometer over the row
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_ge <= !i_occ || (r_rec.key >= i_cmp_key);
            r_eq <= i_occ && (r_rec.key == i_cmp_key);
        end
        if (i_ctl.ins && r_ge) begin
            // take the left neighbor above the slot, the new record at the slot
            r_rec <= i_prev_ge ? i_prev : i_new;
        end else if (i_ctl.del && r_ge) begin
            r_rec <= i_next;
        end
    end

    assign o_rec = r_rec;
    assign o_ge  = r_ge;
    assign o_eq  = r_eq;

endmodule

### design/srt_checker.sv
module srt_checker
    import srt_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_axis_tvalid,
    input logic                o_s_axis_tready,
    input logic [S_DATA_W-1:0] i_s_axis_tdata,
    input logic [S_USER_W-1:0] i_s_axis_tuser,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [M_DATA_W-1:0] o_m_axis_tdata,
    input logic [M_USER_W-1:0] o_m_axis_tuser
);

    localparam bit SMALL = (DEPTH < 128);

    // one item in the row at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second transfer accepted while an item is in the row");

    // a fresh result only follows a cycle with the row busy
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result produced without an item in the row");

    // full status only when the count sits at the table depth
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == ST_FULL) && SMALL |->
            (o_m_axis_tdata[13:7] == 7'(DEPTH)))
        else $error("table full reported with count below depth");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind sorted_record_table srt_checker #(.DEPTH(DEPTH)) u_srt_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import srt_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 1650;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 400;
    localparam int TAIL_CYCLES  = 16;
    localparam int PRINT_CAP    = 50;

    typedef struct packed {
        t_status          status;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] count;
    } t_outcome;

    typedef struct packed {
        t_func              func;
        logic [KEY_W-1:0]   key;
        logic [REF_W-1:0]   offer_ref;
        logic [GRADE_W-1:0] grade;
        logic               fixed;
        t_outcome           want;
    } t_script_row;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIX} t_phase;

    logic                i_clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_valid = 1'b0;
    logic [S_DATA_W-1:0] s_data = '0;
    logic [S_USER_W-1:0] s_user = '0;
    logic                m_ready = 1'b0;
    logic                s_ready;
    logic                m_valid;
    logic [M_DATA_W-1:0] m_data;
    logic [M_USER_W-1:0] m_user;

    // shadow of the table contents
    logic [KEY_W-1:0]   tbl_key   [TABLE_DEPTH];
    logic [REF_W-1:0]   tbl_ref   [TABLE_DEPTH];
    logic [GRADE_W-1:0] tbl_grade [TABLE_DEPTH];
    int                 tbl_count = 0;
    int                 tbl_peak = 0;
    int                 tbl_emptied = 0;

    logic [KEY_W-1:0] key_pool [8] = '{16'h0000, 16'h0001, 16'h0002, 16'h1234,
                                       16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF};

    t_outcome    pending_results[$];
    t_script_row script[$];
    t_outcome    got_result;
    t_outcome    want_result;

    int cycles = 0;
    int mismatches = 0;
    int results_seen = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int burst_left = 0;
    int long_holds = 0;

    sorted_record_table #(
        .DEPTH(TABLE_DEPTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic log_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
            $display("mismatch at result %0d: %s got %0d want %0d",
                     results_seen, what, got, want);
        mismatches++;
    endtask

    // Apply one operation to the shadow table and return what the block must answer.
    function automatic t_outcome apply_op(input t_func f, input logic [KEY_W-1:0] k,
                                          input logic [REF_W-1:0] r,
                                          input logic [GRADE_W-1:0] g);
        t_outcome res;
        int       slot;
        bit       found;
        bit       hit;
        slot  = tbl_count;
        found = 1'b0;
        hit   = 1'b0;
        for (int i = 0; i < tbl_count; i++) begin
            if (!found && tbl_key[i] >= k) begin
                found = 1'b1;
                slot  = i;
                hit   = (tbl_key[i] == k);
            end
        end
        if (f == FUNC_INS) begin
            if (hit) begin
                res.status = ST_DUP;
            end else if (tbl_count >= TABLE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                for (int i = tbl_count; i > slot; i--) begin
                    tbl_key[i]   = tbl_key[i-1];
                    tbl_ref[i]   = tbl_ref[i-1];
                    tbl_grade[i] = tbl_grade[i-1];
                end
                tbl_key[slot]   = k;
                tbl_ref[slot]   = r;
                tbl_grade[slot] = g;
                tbl_count++;
                res.status = ST_DONE;
            end
        end else begin
            if (!hit) begin
                res.status = ST_MISSING;
            end else begin
                for (int i = slot; i + 1 < tbl_count; i++) begin
                    tbl_key[i]   = tbl_key[i+1];
                    tbl_ref[i]   = tbl_ref[i+1];
                    tbl_grade[i] = tbl_grade[i+1];
                end
                tbl_count--;
                if (tbl_count == 0) tbl_emptied++;
                res.status = ST_DONE;
            end
        end
        if (tbl_count > tbl_peak) tbl_peak = tbl_count;
        res.position = slot[POS_W-1:0];
        res.count    = tbl_count[CNT_W-1:0];
        return res;
    endfunction

    function automatic t_script_row mk_row(input t_func f, input logic [KEY_W-1:0] k,
                                           input logic [REF_W-1:0] r,
                                           input logic [GRADE_W-1:0] g, input logic fixed,
                                           input t_status st, input logic [POS_W-1:0] pos,
                                           input logic [CNT_W-1:0] cnt);
        t_script_row row;
        row.func          = f;
        row.key           = k;
        row.offer_ref     = r;
        row.grade         = g;
        row.fixed         = fixed;
        row.want.status   = st;
        row.want.position = pos;
        row.want.count    = cnt;
        return row;
    endfunction

    // Keys already in the table or next to one (75% of delete picks, 40% of insert picks
    // when the table is not empty); the rest is edge keys and full-range noise.
    function automatic logic [KEY_W-1:0] pick_key(input t_func f);
        int sel;
        int hit_pct;
        sel     = $urandom_range(0, 99);
        hit_pct = (f == FUNC_DEL) ? 60 : 25;
        if (tbl_count > 0 && sel < hit_pct)
            return tbl_key[$urandom_range(0, tbl_count - 1)];
        if (tbl_count > 0 && sel < hit_pct + 15)
            return tbl_key[$urandom_range(0, tbl_count - 1)] +
                   (($urandom_range(0, 1) == 1) ? 16'h0001 : 16'hFFFF);
        if (sel < hit_pct + 30)
            return key_pool[$urandom_range(0, 7)];
        return KEY_W'($urandom);
    endfunction

    // Offer one item and hold it until the transfer; bursts with random gaps.
    task automatic offer(input t_func f, input logic [KEY_W-1:0] k,
                         input logic [REF_W-1:0] r, input logic [GRADE_W-1:0] g,
                         input logic fixed, input t_outcome fixed_want);
        t_outcome want;
        int       gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        want = apply_op(f, k, r, g);
        if (fixed) want = fixed_want;
        pending_results.push_back(want);
        s_valid <= 1'b1;
        s_data  <= {{(S_DATA_W - KEY_W - REF_W - GRADE_W){1'b0}}, g, r, k};
        s_user  <= f;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    // Stop offering until every outstanding result has come back.
    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (rst_n && m_valid && m_ready) begin
            results_seen++;
            got_result.status   = t_status'(m_user);
            got_result.position = m_data[POS_W-1:0];
            got_result.count    = m_data[POS_W+CNT_W-1:POS_W];
            if (pending_results.size() == 0) begin
                log_mismatch("result with nothing pending, status", got_result.status, 0);
            end else begin
                want_result = pending_results.pop_front();
                if (got_result.status != want_result.status)
                    log_mismatch("status", got_result.status, want_result.status);
                if (got_result.position != want_result.position)
                    log_mismatch("position", got_result.position, want_result.position);
                if (got_result.count != want_result.count)
                    log_mismatch("count", got_result.count, want_result.count);
                if (m_data[M_DATA_W-1:POS_W+CNT_W] != '0)
                    log_mismatch("tdata pad", m_data[M_DATA_W-1:POS_W+CNT_W], 0);
                status_seen[int'(want_result.status)]++;
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Output side: stretches of steady, random and periodic stalls, plus two long holds.
    initial begin
        int stretch_no;
        int stretch_len;
        int mode;
        int period;
        stretch_no = 0;
        @(posedge i_clk);
        while (!rst_n) @(posedge i_clk);
        forever begin
            stretch_no++;
            if (stretch_no == 6 || stretch_no == 45) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_holds++;
            end
            mode        = $urandom_range(0, 3);
            stretch_len = $urandom_range(16, 160);
            period      = $urandom_range(2, 9);
            for (int c = 0; c < stretch_len; c++) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 99) < 70);
                    2: m_ready <= ((c % period) < (period + 1) / 2);
                    default: m_ready <= ($urandom_range(0, 99) < 25);
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin
        t_phase     phase;
        t_func      f;
        int         phase_len;
        int         ins_pct;
        int         phase_no;
        int         random_sent;
        t_outcome   no_want;
        no_want     = '0;
        phase_no    = 0;
        random_sent = 0;

        // empty table first, then both key extremes, duplicates and misses
        script.push_back(mk_row(FUNC_DEL, 16'h1234, 14'h0000, 11'd0,    1, ST_MISSING, 0, 0));
        script.push_back(mk_row(FUNC_INS, 16'h8000, 14'h3FFF, 11'd2000, 1, ST_DONE,    0, 1));
        script.push_back(mk_row(FUNC_INS, 16'h0000, 14'h0000, 11'd0,    1, ST_DONE,    0, 2));
        script.push_back(mk_row(FUNC_INS, 16'hFFFF, 14'h2AAA, 11'h555,  1, ST_DONE,    2, 3));
        script.push_back(mk_row(FUNC_INS, 16'h8000, 14'h0001, 11'd1,    1, ST_DUP,     1, 3));
        script.push_back(mk_row(FUNC_INS, 16'h7FFF, 14'h1555, 11'h2AA,  1, ST_DONE,    1, 4));
        script.push_back(mk_row(FUNC_DEL, 16'h8001, 14'h0000, 11'd0,    1, ST_MISSING, 3, 4));
        script.push_back(mk_row(FUNC_DEL, 16'h0000, 14'h0000, 11'd0,    1, ST_DONE,    0, 3));
        script.push_back(mk_row(FUNC_DEL, 16'hFFFF, 14'h0000, 11'd0,    1, ST_DONE,    2, 2));
        script.push_back(mk_row(FUNC_INS, 16'h0001, 14'd100,  11'd1999, 0, ST_DONE,    0, 0));
        script.push_back(mk_row(FUNC_DEL, 16'h7FFF, 14'h0000, 11'd0,    0, ST_DONE,    0, 0));
        script.push_back(mk_row(FUNC_DEL, 16'h7FFF, 14'h0000, 11'd0,    0, ST_DONE,    0, 0));
        script.push_back(mk_row(FUNC_INS, 16'hFFFE, 14'h3FFF, 11'd2000, 0, ST_DONE,    0, 0));
        // fields other than the key must be ignored on delete
        script.push_back(mk_row(FUNC_DEL, 16'h8000, 14'h3FFF, 11'd2000, 0, ST_DONE,    0, 0));
        script.push_back(mk_row(FUNC_INS, 16'h8000, 14'h0ABC, 11'd1000, 0, ST_DONE,    0, 0));
        script.push_back(mk_row(FUNC_DEL, 16'h0001, 14'h0000, 11'd0,    0, ST_DONE,    0, 0));
        script.push_back(mk_row(FUNC_DEL, 16'hFFFE, 14'h0000, 11'd0,    0, ST_DONE,    0, 0));
        script.push_back(mk_row(FUNC_DEL, 16'h8000, 14'h0000, 11'd0,    1, ST_DONE,    0, 0));

        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;

        foreach (script[i])
            offer(script[i].func, script[i].key, script[i].offer_ref, script[i].grade,
                  script[i].fixed, script[i].want);
        settle();

        // first phase fills the table past full; later ones wander between full and empty
        while (random_sent < RANDOM_ITEMS) begin
            if (phase_no == 0) begin
                phase     = PH_FILL;
                phase_len = 140;
            end else begin
                phase     = t_phase'($urandom_range(0, 2));
                phase_len = $urandom_range(30, 140);
            end
            case (phase)
                PH_FILL:  ins_pct = 88;
                PH_DRAIN: ins_pct = 12;
                default:  ins_pct = 50;
            endcase
            for (int j = 0; j < phase_len; j++) begin
                f = ($urandom_range(0, 99) < ins_pct) ? FUNC_INS : FUNC_DEL;
                offer(f, pick_key(f), REF_W'($urandom_range(0, 16383)),
                      GRADE_W'($urandom_range(0, 2000)), 0, no_want);
                random_sent++;
            end
            if (phase_no == 0 || $urandom_range(0, 2) == 0) settle();
            phase_no++;
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            log_mismatch("results never delivered", pending_results.size(), 0);

        $display("%0d operations checked in %0d cycles: %0d done, %0d duplicate, %0d full, %0d missing",
                 results_seen, cycles, status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3]);
        $display("table peaked at %0d of %0d entries, emptied %0d times, %0d long output holds",
                 tbl_peak, TABLE_DEPTH, tbl_emptied, long_holds);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### sorted_record_table.f
design/srt_pkg.sv
design/srt_cell.sv
design/sorted_record_table.sv
design/srt_checker.sv
tb/testbench.sv
